FILE: design/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants, types and helpers of the radix digit counter.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

  localparam int MAX_WORDS      = 4;
  localparam int MAX_RADIX_BITS = 32;
  localparam int WORD_BITS      = 64;
  localparam int STEP_BITS      = 4;
  localparam int STEPS          = WORD_BITS / STEP_BITS;
  localparam int BEAT_W         = $clog2(STEPS);
  localparam int WPOS_W         = $clog2(MAX_WORDS + 1);
  localparam int CNT_W          = 9;
  localparam int RADIX_W        = 6;
  localparam int OFF_W          = 5;
  localparam int REM_W          = 5;
  localparam int DIV_STEPS      = CNT_W;
  localparam int DIVC_W         = $clog2(DIV_STEPS + 1);
  localparam int APB_DW         = 32;
  localparam int APB_AW         = 1;

  localparam logic [RADIX_W-1:0] RADIX_RESET     = RADIX_W'(8);
  localparam logic [APB_AW-1:0]  REG_DIGIT_WIDTH = APB_AW'(0);

  typedef struct packed {
    logic [CNT_W-1:0] bit_length;
    logic [CNT_W-1:0] nonzero_total;
    logic [OFF_W-1:0] offset;
    logic             seen;
  } scan_state_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] raw);
    logic [RADIX_W-1:0] r;
    r = raw;
    if (r == '0) r = RADIX_W'(1);
    if (r > RADIX_W'(MAX_RADIX_BITS)) r = RADIX_W'(MAX_RADIX_BITS);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/radix_digit_counter.sv
// ----------------------------------------------------------------------------
// radix_digit_counter
// Digit count and nonzero digit count of a scalar in radix 2^r.
//
// Input channel: one 64-bit scalar word per item, least significant first,
// in_last_word on the final word. Each word held within the first MAX_WORDS
// is scanned four bits a cycle through one shared scan step, so the input
// stalls while an accepted word is scanned. Words beyond MAX_WORDS are
// dropped and only set too_long; a dropped last word still closes the scalar.
// After the last word the digit count is worked out by a restoring divider
// at one quotient bit a cycle; the result item is registered once the
// division is done and the output register is free.
// The result sits in an output register, so a stalled receiver does not
// block scanning of the next scalar; only a second result waits for it.
// Configuration: digit width register at byte address 0 over the APB-style
// port, written while the block is idle. Reset sets the digit width to 8,
// clears the stream statistics and empties the output register; no clearing
// pass.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_counter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rdc_pkg::WORD_BITS-1:0] in_scalar_word,
  input  wire logic                          in_last_word,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [rdc_pkg::CNT_W-1:0]          out_digit_count,
  output logic [rdc_pkg::CNT_W-1:0]          out_nonzero_digit_count,
  output logic                               out_too_long,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rdc_pkg::APB_AW-1:0]    paddr,
  input  wire logic [rdc_pkg::APB_DW-1:0]    pwdata,
  output logic [rdc_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DIV} state_t;

  state_t                        state_r, state_nxt;
  logic [rdc_pkg::RADIX_W-1:0]   radix_r, radix_nxt;
  rdc_pkg::scan_state_t          st_r, st_nxt, scan_out;
  logic [rdc_pkg::WPOS_W-1:0]    wpos_r, wpos_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [rdc_pkg::BEAT_W-1:0]    beat_r, beat_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [rdc_pkg::CNT_W-1:0]     nz_r, nz_nxt;
  logic                          tl_r, tl_nxt;
  logic [rdc_pkg::CNT_W-1:0]     dc_r, dc_nxt;
  logic [rdc_pkg::CNT_W-1:0]     onz_r, onz_nxt;
  logic                          otl_r, otl_nxt;
  logic [rdc_pkg::WORD_BITS-1:0] word_r, word_nxt;
  logic                          last_r, last_nxt;

  logic                          in_acc;
  logic                          cfg_wr;
  logic                          div_start;
  logic [rdc_pkg::CNT_W-1:0]     div_dividend;
  logic                          div_done;
  logic [rdc_pkg::CNT_W-1:0]     div_quo;
  logic [rdc_pkg::RADIX_W-1:0]   radix_eff;
  logic [rdc_pkg::CNT_W-1:0]     base_pos;
  logic                          out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr == rdc_pkg::REG_DIGIT_WIDTH)
                     ? rdc_pkg::APB_DW'(radix_r) : '0;
  assign radix_eff = rdc_pkg::eff_radix(radix_r);
  assign out_free  = !(out_valid_r && out_stall);
  assign base_pos  = (rdc_pkg::CNT_W'(wpos_r) << $clog2(rdc_pkg::WORD_BITS))
                   | (rdc_pkg::CNT_W'(beat_r) << $clog2(rdc_pkg::STEP_BITS));

  rdc_scan u_scan (
    .nib      (word_r[rdc_pkg::STEP_BITS-1:0]),
    .base_pos (base_pos),
    .radix    (radix_eff),
    .cur      (st_r),
    .nxt      (scan_out)
  );

  rdc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (radix_eff),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    radix_nxt     = radix_r;
    st_nxt        = st_r;
    wpos_nxt      = wpos_r;
    ovf_nxt       = ovf_r;
    beat_nxt      = beat_r;
    nz_nxt        = nz_r;
    tl_nxt        = tl_r;
    dc_nxt        = dc_r;
    onz_nxt       = onz_r;
    otl_nxt       = otl_r;
    word_nxt      = word_r;
    last_nxt      = last_r;
    div_start     = 1'b0;
    div_dividend  = st_r.bit_length;
    out_valid_nxt = out_valid_r && out_stall;

    if (cfg_wr && paddr == rdc_pkg::REG_DIGIT_WIDTH) begin
      radix_nxt = pwdata[rdc_pkg::RADIX_W-1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (wpos_r < rdc_pkg::WPOS_W'(rdc_pkg::MAX_WORDS)) begin
            word_nxt  = in_scalar_word;
            last_nxt  = in_last_word;
            beat_nxt  = '0;
            state_nxt = S_SCAN;
          end else begin
            ovf_nxt = 1'b1;
            if (in_last_word) begin
              // dropped last word still closes the scalar
              div_start    = 1'b1;
              div_dividend = st_r.bit_length;
              nz_nxt       = st_r.nonzero_total + rdc_pkg::CNT_W'(st_r.seen);
              tl_nxt       = 1'b1;
              st_nxt       = '0;
              wpos_nxt     = '0;
              ovf_nxt      = 1'b0;
              state_nxt    = S_DIV;
            end
          end
        end
      end
      S_SCAN: begin
        st_nxt   = scan_out;
        word_nxt = word_r >> rdc_pkg::STEP_BITS;
        beat_nxt = beat_r + rdc_pkg::BEAT_W'(1);
        if (beat_r == rdc_pkg::BEAT_W'(rdc_pkg::STEPS - 1)) begin
          wpos_nxt  = wpos_r + rdc_pkg::WPOS_W'(1);
          state_nxt = S_IDLE;
          if (last_r) begin
            div_start    = 1'b1;
            div_dividend = scan_out.bit_length;
            nz_nxt       = scan_out.nonzero_total + rdc_pkg::CNT_W'(scan_out.seen);
            tl_nxt       = ovf_r;
            st_nxt       = '0;
            wpos_nxt     = '0;
            ovf_nxt      = 1'b0;
            state_nxt    = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done && out_free) begin
          dc_nxt        = div_quo;
          onz_nxt       = nz_r;
          otl_nxt       = tl_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radix_r     <= rdc_pkg::RADIX_RESET;
      st_r        <= '0;
      wpos_r      <= '0;
      ovf_r       <= 1'b0;
      beat_r      <= '0;
      out_valid_r <= 1'b0;
      dc_r        <= '0;
      onz_r       <= '0;
      otl_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radix_r     <= radix_nxt;
      st_r        <= st_nxt;
      wpos_r      <= wpos_nxt;
      ovf_r       <= ovf_nxt;
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
      dc_r        <= dc_nxt;
      onz_r       <= onz_nxt;
      otl_r       <= otl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    last_r <= last_nxt;
    nz_r   <= nz_nxt;
    tl_r   <= tl_nxt;
  end

  assign out_valid               = out_valid_r;
  assign out_digit_count         = dc_r;
  assign out_nonzero_digit_count = onz_r;
  assign out_too_long            = otl_r;

endmodule

`default_nettype wire

FILE: design/rdc_scan.sv
// ----------------------------------------------------------------------------
// rdc_scan
// Bit scan step: folds a few scalar bits into the digit statistics.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_scan (
  input  wire logic [rdc_pkg::STEP_BITS-1:0] nib,
  input  wire logic [rdc_pkg::CNT_W-1:0]     base_pos,
  input  wire logic [rdc_pkg::RADIX_W-1:0]   radix,
  input  wire rdc_pkg::scan_state_t          cur,
  output rdc_pkg::scan_state_t               nxt
);

  always_comb begin
    logic [rdc_pkg::RADIX_W-1:0] t_off;
    rdc_pkg::scan_state_t        s;
    s     = cur;
    t_off = rdc_pkg::RADIX_W'(cur.offset);
    for (int i = 0; i < rdc_pkg::STEP_BITS; i++) begin
      if (nib[i]) begin
        s.bit_length = base_pos + rdc_pkg::CNT_W'(i + 1);
        s.seen       = 1'b1;
      end
      t_off = t_off + rdc_pkg::RADIX_W'(1);
      if (t_off >= radix) begin
        s.nonzero_total = s.nonzero_total + rdc_pkg::CNT_W'(s.seen);
        s.seen          = 1'b0;
        t_off           = '0;
      end
    end
    s.offset = t_off[rdc_pkg::OFF_W-1:0];
    nxt      = s;
  end

endmodule

`default_nettype wire

FILE: design/rdc_div.sv
// ----------------------------------------------------------------------------
// rdc_div
// Restoring divider, one quotient bit a cycle, rounding the quotient up.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rdc_pkg::CNT_W-1:0]   dividend,
  input  wire logic [rdc_pkg::RADIX_W-1:0] divisor,
  output logic                             done,
  output logic [rdc_pkg::CNT_W-1:0]        quotient
);

  logic [rdc_pkg::REM_W-1:0]   rem_r, rem_nxt;
  logic [rdc_pkg::CNT_W-1:0]   quo_r, quo_nxt;
  logic [rdc_pkg::CNT_W-1:0]   num_r, num_nxt;
  logic [rdc_pkg::RADIX_W-1:0] den_r, den_nxt;
  logic [rdc_pkg::DIVC_W-1:0]  cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [rdc_pkg::RADIX_W-1:0] trial;
  logic [rdc_pkg::RADIX_W-1:0] diff;

  assign trial = {rem_r, num_r[rdc_pkg::CNT_W-1]};
  assign diff  = trial - den_r;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = '0;
      num_nxt  = dividend;
      den_nxt  = divisor;
      cnt_nxt  = rdc_pkg::DIVC_W'(rdc_pkg::DIV_STEPS);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      num_nxt = num_r << 1;
      if (trial >= den_r) begin
        rem_nxt = diff[rdc_pkg::REM_W-1:0];
        quo_nxt = {quo_r[rdc_pkg::CNT_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[rdc_pkg::REM_W-1:0];
        quo_nxt = {quo_r[rdc_pkg::CNT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - rdc_pkg::DIVC_W'(1);
      if (cnt_r == rdc_pkg::DIVC_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r + rdc_pkg::CNT_W'(rem_r != '0);

endmodule

`default_nettype wire

FILE: design/rdc_checker.sv
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks of the radix digit counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire logic                      in_last_word,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [rdc_pkg::CNT_W-1:0] out_digit_count,
  input wire logic [rdc_pkg::CNT_W-1:0] out_nonzero_digit_count,
  input wire logic                      out_too_long
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digit_count)
      && $stable(out_nonzero_digit_count) && $stable(out_too_long))
    else $error("stalled result item changed");

  // no set bit means no digits, and the other way round
  a_zero_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_digit_count == '0) == (out_nonzero_digit_count == '0)))
    else $error("digit counts disagree on a zero scalar");

  // a result never appears the cycle after an item is taken
  a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result item too early");

  // the last word keeps the block busy
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_word |=> in_stall)
    else $error("input taken right after last word");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present after reset");

endmodule

bind radix_digit_counter rdc_checker u_rdc_checker (.*);

`default_nettype wire
